// File: src/cvah_pkg.sv
// ----------------------------------------------------------------------------
// cvah_pkg: shared types and constants for column_value_at_height
// Field widths, register indexes, placement codes and divider status.
// ----------------------------------------------------------------------------
`default_nettype none

package cvah_pkg;

  localparam int unsigned MAX_LEVELS_DEF = 128;

  localparam int unsigned HGT_W     = 32;  // level/target height, Q20.12
  localparam int unsigned VAL_W     = 32;  // field value, Q16.16
  localparam int unsigned LIU_W     = 8;   // levels_in_use register
  localparam int unsigned CFG_W     = 32;  // widest register
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned PLACE_W   = 2;

  // serial divider operand widths: |numerator| < 2^64, |height step| < 2^32
  localparam int unsigned DIV_NUM_W = 64;
  localparam int unsigned DIV_DEN_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_HEIGHT = 1'b0,
    REG_LEVELS_IN_USE = 1'b1
  } cfg_reg_e;

  typedef enum logic [PLACE_W-1:0] {
    PLACE_INTERP = 2'd0,
    PLACE_FIRST  = 2'd1,
    PLACE_LAST   = 2'd2
  } place_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// File: src/cvah_lvl_if.sv
// ----------------------------------------------------------------------------
// cvah_lvl_if: level input channel
// Carries one column level per word: its height and its field value.
// ----------------------------------------------------------------------------
`default_nettype none

interface cvah_lvl_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [cvah_pkg::HGT_W-1:0]    level_height;
  logic signed [cvah_pkg::VAL_W-1:0]    level_value;

  modport source (output valid, output level_height, output level_value, input ready);
  modport sink   (input valid, input level_height, input level_value, output ready);
endinterface

`default_nettype wire

// File: src/cvah_res_if.sv
// ----------------------------------------------------------------------------
// cvah_res_if: result output channel
// Carries the sampled value and its placement code.
// ----------------------------------------------------------------------------
`default_nettype none

interface cvah_res_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [cvah_pkg::VAL_W-1:0]    sampled_value;
  logic        [cvah_pkg::PLACE_W-1:0]  placement;

  modport source (output valid, output sampled_value, output placement, input ready);
  modport sink   (input valid, input sampled_value, input placement, output ready);
endinterface

`default_nettype wire

// File: src/cvah_ram.sv
// ----------------------------------------------------------------------------
// cvah_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module cvah_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: src/cvah_div.sv
// ----------------------------------------------------------------------------
// cvah_div: serial unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cvah_div #(
  parameter int unsigned DW = cvah_pkg::DIV_NUM_W,
  parameter int unsigned VW = cvah_pkg::DIV_DEN_W
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [DW-1:0]       dividend_i,
  input  wire logic [VW-1:0]       divisor_i,   // nonzero
  output logic      [DW-1:0]       quotient_o,
  output cvah_pkg::div_stat_t      stat_o
);

  localparam int unsigned CNTW = $clog2(DW + 1);

  logic [VW-1:0]   rem_q, rem_d;
  logic [DW-1:0]   quo_q, quo_d;
  logic [VW-1:0]   dvs_q, dvs_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [VW:0]     rem_sh;
  logic [VW:0]     diff;

  always_comb begin
    rem_sh = {rem_q, quo_q[DW-1]};
    diff   = rem_sh - {1'b0, dvs_q};
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = CNTW'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in the next dividend bit, subtract when it fits
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = diff[VW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[VW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      dvs_q  <= dvs_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

`default_nettype wire

// File: src/column_value_at_height.sv
// ----------------------------------------------------------------------------
// column_value_at_height: sample a column's field at a target height
// Loads column levels, binary-searches for the bracketing pair and
// interpolates linearly with a shared multiplier and a serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   lvl_i takes one level per word, top level first, heights falling. While
//   the block is loading it takes a word every cycle. The word that brings
//   the level count up to levels_in_use (saturated into [2, MAX_LEVELS])
//   completes the column and starts the sampling sequence; lvl_i.ready then
//   stays low until the result has been placed in the output register.
//   Sampling runs a read and a compare per search step (ceil(log2 N) steps at
//   most), the final read and compare, the fetch of the bracketing levels,
//   then the multiplies, the sum, the divider start, the divide and the
//   hand-over of the result; a clamped word skips the arithmetic and is done
//   far sooner. The single RAM read port and the one-bit-per-cycle divider
//   set the length of this sequence.
//   res_o holds one word in an output register. While the receiver stalls,
//   the next column still loads; only a second finished result waits.
//   cfg_we_i/cfg_idx_i/cfg_data_i write target_height (index 0) or
//   levels_in_use (index 1).
//   Reset clears the level count and returns target_height to 0 and
//   levels_in_use to 128; the level RAMs are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module column_value_at_height #(
  parameter int unsigned MAX_LEVELS = cvah_pkg::MAX_LEVELS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [cvah_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [cvah_pkg::CFG_W-1:0]      cfg_data_i,
  cvah_lvl_if.sink                             lvl_i,
  cvah_res_if.source                           res_o
);

  localparam int unsigned AW = $clog2(MAX_LEVELS);       // level address
  localparam int unsigned CW = $clog2(MAX_LEVELS + 1);   // level count
  localparam int unsigned NW = (CW > cvah_pkg::LIU_W) ? CW : cvah_pkg::LIU_W;
  localparam int unsigned HW = cvah_pkg::HGT_W;
  localparam int unsigned VW = cvah_pkg::VAL_W;
  localparam int unsigned PW = HW + 1 + VW;               // product width
  localparam int unsigned SW = PW + 1;                    // sum width
  localparam int unsigned DNW = cvah_pkg::DIV_NUM_W;
  localparam int unsigned DDW = cvah_pkg::DIV_DEN_W;

  typedef enum logic [3:0] {
    S_LOAD,
    S_MID_RD,
    S_MID_CMP,
    S_LO_RD,
    S_LO_CMP,
    S_FETCH_A,
    S_FETCH_B,
    S_FETCH_C,
    S_MUL_A,
    S_MUL_B,
    S_SUM,
    S_DIV_GO,
    S_DIV_WAIT,
    S_DONE
  } state_e;

  // configuration registers
  logic signed [HW-1:0]             target_q;
  logic [cvah_pkg::LIU_W-1:0]       liu_q;

  // sequencer state
  state_e                           state_q, state_d;
  logic [AW-1:0]                    cnt_q, cnt_d;
  logic [CW-1:0]                    n_q, n_d;
  logic [CW-1:0]                    lo_q, lo_d;
  logic [CW-1:0]                    hi_q, hi_d;
  logic [CW-1:0]                    pos_q, pos_d;
  cvah_pkg::place_e                 place_q, place_d;

  // datapath registers
  logic signed [HW-1:0]             h0_q, h0_d, h1_q, h1_d;
  logic signed [VW-1:0]             v0_q, v0_d, v1_q, v1_d;
  logic signed [PW-1:0]             pa_q, pa_d, pb_q, pb_d;
  logic signed [SW-1:0]             num_q, num_d;
  logic signed [HW:0]               den_q, den_d;
  logic                             neg_q, neg_d;
  logic signed [VW-1:0]             res_q, res_d;

  // output register
  logic                             out_vld_q, out_vld_d;
  logic signed [VW-1:0]             out_val_q, out_val_d;
  cvah_pkg::place_e                 out_place_q, out_place_d;

  // RAM ports
  logic                             ram_we;
  logic [AW-1:0]                    ram_raddr;
  logic [HW-1:0]                    h_rd;
  logic [VW-1:0]                    v_rd;

  // shared multiplier
  logic signed [HW:0]               mul_a;
  logic signed [VW-1:0]             mul_b;
  logic signed [PW-1:0]             prod;

  // divider
  logic                             div_start;
  logic [DNW-1:0]                   div_num;
  logic [DDW-1:0]                   div_den;
  logic [DNW-1:0]                   div_quo;
  cvah_pkg::div_stat_t              div_stat;

  // combinational helpers
  logic [NW-1:0]                    liu_ext;
  logic [CW-1:0]                    n_cur;
  logic [CW-1:0]                    cnt_inc;
  logic [CW-1:0]                    span;
  logic [CW-1:0]                    mid_w;
  logic [SW-1:0]                    num_mag;
  logic [HW:0]                      den_mag;
  logic                             lvl_acc;
  logic                             out_free;

  // --------------------------------------------------------------------------
  // Configuration writes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      liu_q    <= cvah_pkg::LIU_W'(128);
    end else if (cfg_we_i) begin
      case (cvah_pkg::cfg_reg_e'(cfg_idx_i))
        cvah_pkg::REG_TARGET_HEIGHT: target_q <= $signed(cfg_data_i[HW-1:0]);
        cvah_pkg::REG_LEVELS_IN_USE: liu_q    <= cfg_data_i[cvah_pkg::LIU_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Level storage: heights and values in two RAMs at the same address
  // --------------------------------------------------------------------------
  cvah_ram #(.WIDTH(HW), .DEPTH(MAX_LEVELS)) u_hgt_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q),
    .wdata_i (lvl_i.level_height),
    .raddr_i (ram_raddr),
    .rdata_o (h_rd)
  );

  cvah_ram #(.WIDTH(VW), .DEPTH(MAX_LEVELS)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q),
    .wdata_i (lvl_i.level_value),
    .raddr_i (ram_raddr),
    .rdata_o (v_rd)
  );

  cvah_div #(.DW(DNW), .VW(DDW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .quotient_o (div_quo),
    .stat_o     (div_stat)
  );

  // --------------------------------------------------------------------------
  // Level count saturated into [2, MAX_LEVELS]
  // --------------------------------------------------------------------------
  always_comb begin
    liu_ext = NW'(liu_q);
    if (liu_ext < NW'(2)) begin
      n_cur = CW'(2);
    end else if (liu_ext > NW'(MAX_LEVELS)) begin
      n_cur = CW'(MAX_LEVELS);
    end else begin
      n_cur = liu_ext[CW-1:0];
    end
  end

  assign lvl_i.ready = (state_q == S_LOAD);
  assign lvl_acc     = lvl_i.valid && lvl_i.ready;
  assign ram_we      = lvl_acc;
  assign cnt_inc     = CW'(cnt_q) + CW'(1);

  // probe below the midpoint of the open interval
  assign span  = hi_q - lo_q;
  assign mid_w = lo_q + (span >> 1) - CW'(1);

  // the one multiplier: (t - h[p-1]) * v[p], then (h[p] - t) * v[p-1]
  always_comb begin
    if (state_q == S_MUL_B) begin
      mul_a = {h1_q[HW-1], h1_q} - {target_q[HW-1], target_q};
      mul_b = v0_q;
    end else begin
      mul_a = {target_q[HW-1], target_q} - {h0_q[HW-1], h0_q};
      mul_b = v1_q;
    end
  end
  assign prod = mul_a * mul_b;

  assign num_mag  = num_q[SW-1] ? -num_q : num_q;
  assign den_mag  = den_q[HW] ? -den_q : den_q;
  assign div_num  = num_mag[DNW-1:0];
  assign div_den  = den_mag[DDW-1:0];
  assign out_free = !out_vld_q || res_o.ready;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    pos_d       = pos_q;
    place_d     = place_q;
    h0_d        = h0_q;
    h1_d        = h1_q;
    v0_d        = v0_q;
    v1_d        = v1_q;
    pa_d        = pa_q;
    pb_d        = pb_q;
    num_d       = num_q;
    den_d       = den_q;
    neg_d       = neg_q;
    res_d       = res_q;
    out_vld_d   = out_vld_q && !res_o.ready;
    out_val_d   = out_val_q;
    out_place_d = out_place_q;
    ram_raddr   = lo_q[AW-1:0];
    div_start   = 1'b0;

    case (state_q)
      S_LOAD: begin
        if (lvl_acc) begin
          if (cnt_inc >= n_cur) begin
            // column complete: open the search on [0, N)
            cnt_d   = '0;
            n_d     = n_cur;
            lo_d    = '0;
            hi_d    = n_cur;
            state_d = S_MID_RD;
          end else begin
            cnt_d = cnt_inc[AW-1:0];
          end
        end
      end

      S_MID_RD: begin
        ram_raddr = mid_w[AW-1:0];
        state_d   = S_MID_CMP;
      end

      S_MID_CMP: begin
        if ($signed(h_rd) >= target_q) begin
          lo_d = mid_w + CW'(1);
        end else begin
          hi_d = mid_w + CW'(1);
        end
        state_d = ((hi_d - lo_d) > CW'(1)) ? S_MID_RD : S_LO_RD;
      end

      S_LO_RD: begin
        ram_raddr = lo_q[AW-1:0];
        state_d   = S_LO_CMP;
      end

      S_LO_CMP: begin
        pos_d = ($signed(h_rd) < target_q) ? lo_q : hi_q;
        if (pos_d == '0) begin
          place_d = cvah_pkg::PLACE_FIRST;
        end else if (pos_d >= n_q) begin
          place_d = cvah_pkg::PLACE_LAST;
        end else begin
          place_d = cvah_pkg::PLACE_INTERP;
        end
        state_d = S_FETCH_A;
      end

      S_FETCH_A: begin
        case (place_q)
          cvah_pkg::PLACE_FIRST: ram_raddr = '0;
          cvah_pkg::PLACE_LAST:  ram_raddr = AW'(n_q - CW'(1));
          default:               ram_raddr = AW'(pos_q - CW'(1));
        endcase
        state_d = S_FETCH_B;
      end

      S_FETCH_B: begin
        h0_d      = $signed(h_rd);
        v0_d      = $signed(v_rd);
        ram_raddr = pos_q[AW-1:0];
        if (place_q != cvah_pkg::PLACE_INTERP) begin
          res_d   = $signed(v_rd);
          state_d = S_DONE;
        end else begin
          state_d = S_FETCH_C;
        end
      end

      S_FETCH_C: begin
        h1_d    = $signed(h_rd);
        v1_d    = $signed(v_rd);
        state_d = S_MUL_A;
      end

      S_MUL_A: begin
        pa_d    = prod;
        state_d = S_MUL_B;
      end

      S_MUL_B: begin
        pb_d    = prod;
        state_d = S_SUM;
      end

      S_SUM: begin
        num_d   = {pa_q[PW-1], pa_q} + {pb_q[PW-1], pb_q};
        den_d   = {h1_q[HW-1], h1_q} - {h0_q[HW-1], h0_q};
        state_d = S_DIV_GO;
      end

      S_DIV_GO: begin
        if (den_q == '0) begin
          // flat step: take the upper level's value
          res_d   = v0_q;
          state_d = S_DONE;
        end else begin
          div_start = 1'b1;
          neg_d     = num_q[SW-1] ^ den_q[HW];
          state_d   = S_DIV_WAIT;
        end
      end

      S_DIV_WAIT: begin
        if (div_stat.done) begin
          // truncated quotient, saturated to 32 bits
          if (neg_d) begin
            if (|div_quo[DNW-1:VW-1]) begin
              res_d = {1'b1, {(VW-1){1'b0}}};
            end else begin
              res_d = -$signed(div_quo[VW-1:0]);
            end
          end else begin
            if (|div_quo[DNW-1:VW-1]) begin
              res_d = {1'b0, {(VW-1){1'b1}}};
            end else begin
              res_d = $signed(div_quo[VW-1:0]);
            end
          end
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_vld_d   = 1'b1;
          out_val_d   = res_q;
          out_place_d = place_q;
          state_d     = S_LOAD;
        end
      end

      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      cnt_q       <= '0;
      n_q         <= CW'(2);
      lo_q        <= '0;
      hi_q        <= '0;
      pos_q       <= '0;
      place_q     <= cvah_pkg::PLACE_INTERP;
      h0_q        <= '0;
      h1_q        <= '0;
      v0_q        <= '0;
      v1_q        <= '0;
      pa_q        <= '0;
      pb_q        <= '0;
      num_q       <= '0;
      den_q       <= '0;
      neg_q       <= 1'b0;
      res_q       <= '0;
      out_vld_q   <= 1'b0;
      out_val_q   <= '0;
      out_place_q <= cvah_pkg::PLACE_INTERP;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      pos_q       <= pos_d;
      place_q     <= place_d;
      h0_q        <= h0_d;
      h1_q        <= h1_d;
      v0_q        <= v0_d;
      v1_q        <= v1_d;
      pa_q        <= pa_d;
      pb_q        <= pb_d;
      num_q       <= num_d;
      den_q       <= den_d;
      neg_q       <= neg_d;
      res_q       <= res_d;
      out_vld_q   <= out_vld_d;
      out_val_q   <= out_val_d;
      out_place_q <= out_place_d;
    end
  end

  assign res_o.valid         = out_vld_q;
  assign res_o.sampled_value = out_val_q;
  assign res_o.placement     = out_place_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(state_q == S_DONE))
    else $error("result word raised outside the hand-over state");

  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> (state_q == S_DIV_WAIT))
    else $error("divider busy while the sequencer is not waiting on it");

  a_search_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MID_RD) |-> ((hi_q - lo_q) > CW'(1)))
    else $error("search probe issued on a closed interval");

  a_load_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lvl_acc && (cnt_inc >= n_cur)) |=> !lvl_i.ready)
    else $error("level input still open after the column completed");

endmodule

`default_nettype wire
